// ===== hdl/ppmd_pkg.sv =====
// Shared types and constants for the pulse period meter with decimal report.
package ppmd_pkg;

  // Measurement counter width and number of decimal digits in a report
  localparam int COUNT_WIDTH = 16;
  localparam int DIGITS      = 5;

  // Period value after saturation, and its ceiling
  localparam int          VALUE_W   = 16;
  localparam logic [15:0] VALUE_MAX = 16'hFFFF;

  // Divide by ten: q = (v * RECIP) >> RECIP_SHIFT is exact for 16-bit v
  localparam int          RECIP_W     = 17;
  localparam logic [16:0] RECIP       = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  // Report characters
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;

  // Index widths for the digit store and the character counter
  localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CHAR_W = $clog2(DIGITS + 2);

  // Configuration registers
  localparam int          PRESCALE_W      = 11;
  localparam int          HOLDOFF_W       = 20;
  localparam int          PCNT_W          = 10;
  localparam logic [10:0] PRESCALE_MAX    = 11'd1024;
  localparam logic [10:0] PRESCALE_RESET  = 11'd256;
  localparam logic [19:0] HOLDOFF_RESET   = 20'd400000;
  localparam int          PADDR_W         = 3;
  localparam logic        REG_PRESCALE    = 1'b0;
  localparam logic        REG_HOLDOFF     = 1'b1;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [PRESCALE_W-1:0] prescale_div;
    logic [HOLDOFF_W-1:0]  holdoff_ticks;
  } cfg_t;

  // Queue status towards front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/ppmd_front.sv =====
// Front end: takes pin samples, runs the period measurement and queues results.
module ppmd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        pin_level,
  input  ppmd_pkg::cfg_t              cfg,
  input  ppmd_pkg::q_status_t         q_status,
  output logic                        push,
  output logic [ppmd_pkg::VALUE_W-1:0] push_value
);
  import ppmd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_HOLD = 4'b1000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [PCNT_W-1:0]      prescale_count, prescale_count_next;
  logic [COUNT_WIDTH-1:0] period_count, period_count_next;
  logic [HOLDOFF_W-1:0]   holdoff_count, holdoff_count_next;

  logic                   accept;
  logic [PRESCALE_W-1:0]  div_eff;
  logic [PCNT_W:0]        pcnt_inc;
  logic [PCNT_W-1:0]      tick_pcnt;
  logic [COUNT_WIDTH-1:0] tick_period;
  logic [COUNT_WIDTH+7:0] scaled;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // Clamp the prescale divider into 1..1024
  always_comb begin
    priority if (cfg.prescale_div == '0) begin
      div_eff = PRESCALE_W'(1);
    end else if (cfg.prescale_div > PRESCALE_MAX) begin
      div_eff = PRESCALE_MAX;
    end else begin
      div_eff = cfg.prescale_div;
    end
  end

  // Advance prescaler, and the period counter on prescaler wrap
  always_comb begin
    pcnt_inc = {1'b0, prescale_count} + (PCNT_W+1)'(1);
    if (pcnt_inc >= div_eff) begin
      tick_pcnt   = '0;
      tick_period = period_count + COUNT_WIDTH'(1);
    end else begin
      tick_pcnt   = pcnt_inc[PCNT_W-1:0];
      tick_period = period_count;
    end
  end

  // Period in units of 256 us, saturated to 16 bits
  assign scaled = {period_count >> 2, 8'h00};
  always_comb begin
    if (scaled > (COUNT_WIDTH+8)'(VALUE_MAX)) begin
      push_value = VALUE_MAX;
    end else begin
      push_value = scaled[VALUE_W-1:0];
    end
  end

  assign push = accept && (phase == PH_LOW) && pin_level;

  // Measurement sequencer
  always_comb begin
    phase_next          = phase;
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    holdoff_count_next  = holdoff_count;
    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (pin_level) begin
            period_count_next   = '0;
            prescale_count_next = '0;
            phase_next          = PH_HIGH;
          end
        end
        PH_HIGH: begin
          prescale_count_next = tick_pcnt;
          period_count_next   = tick_period;
          if (!pin_level) begin
            phase_next = PH_LOW;
          end
        end
        PH_LOW: begin
          if (pin_level) begin
            holdoff_count_next = cfg.holdoff_ticks;
            phase_next = (cfg.holdoff_ticks == '0) ? PH_IDLE : PH_HOLD;
          end else begin
            prescale_count_next = tick_pcnt;
            period_count_next   = tick_period;
          end
        end
        PH_HOLD: begin
          if (holdoff_count != '0) begin
            holdoff_count_next = holdoff_count - HOLDOFF_W'(1);
          end
          if (holdoff_count <= HOLDOFF_W'(1)) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prescale_count <= '0;
      period_count   <= '0;
      holdoff_count  <= '0;
    end else begin
      phase          <= phase_next;
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
      holdoff_count  <= holdoff_count_next;
    end
  end

endmodule

// ===== hdl/ppmd_queue.sv =====
// Two-entry queue carrying measured period values from front to back.
module ppmd_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [ppmd_pkg::VALUE_W-1:0] push_value,
  input  logic                         pop,
  output logic [ppmd_pkg::VALUE_W-1:0] head_value,
  output ppmd_pkg::q_status_t          status
);
  import ppmd_pkg::*;

  logic [VALUE_W-1:0] entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_value   = entries[rd_ptr];

  // Hold pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Store entry data
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_value;
    end
  end

endmodule

// ===== hdl/ppmd_back.sv =====
// Back end: converts a period value to decimal and sends the report line.
module ppmd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ppmd_pkg::q_status_t          q_status,
  input  logic [ppmd_pkg::VALUE_W-1:0] head_value,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   ascii_char,
  output logic                         last_of_run
);
  import ppmd_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CONV = 3'b010,
    B_SEND = 3'b100
  } bstate_t;

  bstate_t                    state;
  logic [VALUE_W-1:0]         value;
  logic [DIG_W-1:0]           dig_idx;
  logic [CHAR_W-1:0]          char_idx;
  logic [3:0]                 digits [DIGITS];

  logic [VALUE_W+RECIP_W-1:0] prod;
  logic [VALUE_W-1:0]         quot;
  logic [VALUE_W-1:0]         rem_full;
  logic                       out_slot;
  logic [7:0]                 char_next;
  logic                       last_next;

  assign pop = (state == B_IDLE) && !q_status.empty;

  // Divide by ten through the reciprocal and take the remainder
  assign prod     = (VALUE_W+RECIP_W)'(value) * (VALUE_W+RECIP_W)'(RECIP);
  assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
  assign rem_full = value - ((quot << 3) + (quot << 1));

  // Output register frees up when empty or when its transfer completes
  assign out_slot = !out_valid || !out_stall;

  // Pick the next character of the line
  always_comb begin
    last_next = 1'b0;
    priority if (char_idx < CHAR_W'(DIGITS)) begin
      char_next = CHAR_ZERO + {4'h0, digits[char_idx[DIG_W-1:0]]};
    end else if (char_idx == CHAR_W'(DIGITS)) begin
      char_next = CHAR_CR;
    end else begin
      char_next = CHAR_LF;
      last_next = 1'b1;
    end
  end

  // Sequence conversion and sending
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      dig_idx   <= '0;
      char_idx  <= '0;
    end else begin
      if (out_slot) begin
        out_valid <= (state == B_SEND);
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            dig_idx <= DIG_W'(DIGITS - 1);
            state   <= B_CONV;
          end
        end
        B_CONV: begin
          if (dig_idx == '0) begin
            char_idx <= '0;
            state    <= B_SEND;
          end else begin
            dig_idx <= dig_idx - DIG_W'(1);
          end
        end
        B_SEND: begin
          if (out_slot) begin
            char_idx <= char_idx + CHAR_W'(1);
            if (last_next) begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Hold value, digits and the output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      value <= head_value;
    end else if (state == B_CONV) begin
      value           <= quot;
      digits[dig_idx] <= rem_full[3:0];
    end
    if (out_slot && (state == B_SEND)) begin
      ascii_char  <= char_next;
      last_of_run <= last_next;
    end
  end

endmodule

// ===== hdl/pulse_period_meter_decimal.sv =====
// Top level of the pulse period meter with decimal ASCII report.
//
// Input channel: one pin sample (pin_level) per transfer, normally one per
// clock. A high level while armed starts a measurement; the counter advances
// once every prescale_div samples through the high and low phases, and the
// next high level stops it. Output channel: one character per transfer,
// five decimal digits of floor(count/4)*256, saturated at 65535, then CR,
// then LF with last_of_run set.
// Throughput: one input sample per cycle. The front end and the back end
// are parted by a two-entry queue; the input stalls only while that queue
// is full. The back end handles one report at a time (one to fetch, five
// divide-by-ten steps on one multiplier, seven characters), so reports
// arriving faster than it sends them fill the queue. The stopping sample's
// value is queued, fetched and converted, then the first character is
// registered for output; the rest follow one a cycle while out_stall is low.
// When out_stall is high the current character holds in the output register.
// Reset (rst, synchronous) clears the measurement, the queue and the output,
// and loads prescale_div = 256 and holdoff_ticks = 400000.
// Registers over APB: prescale_div at 0x0, holdoff_ticks at 0x4.
module pulse_period_meter_decimal (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pin_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    ascii_char,
  output logic                          last_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ppmd_pkg::*;

  cfg_t               cfg;
  q_status_t          q_status;
  logic               push;
  logic [VALUE_W-1:0] push_value;
  logic               pop;
  logic [VALUE_W-1:0] head_value;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_div  <= PRESCALE_RESET;
      cfg.holdoff_ticks <= HOLDOFF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_PRESCALE: cfg.prescale_div  <= pwdata[PRESCALE_W-1:0];
        REG_HOLDOFF:  cfg.holdoff_ticks <= pwdata[HOLDOFF_W-1:0];
        default:      cfg.prescale_div  <= cfg.prescale_div;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_PRESCALE: prdata = 32'(cfg.prescale_div);
      REG_HOLDOFF:  prdata = 32'(cfg.holdoff_ticks);
      default:      prdata = '0;
    endcase
  end

  ppmd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pin_level  (pin_level),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (push),
    .push_value (push_value)
  );

  ppmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .pop        (pop),
    .head_value (head_value),
    .status     (q_status)
  );

  ppmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head_value  (head_value),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_char  (ascii_char),
    .last_of_run (last_of_run)
  );

endmodule
